>>> rtl/mfrq_pkg.sv
// ----------------------------------------------------------------------------
// mfrq_pkg
// Shared opcodes, register indexes and transaction types of the ready queue.
// ----------------------------------------------------------------------------
package mfrq_pkg;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_INSERT   = 3'd1;
    localparam logic [2:0] OP_DISPATCH = 3'd2;
    localparam logic [2:0] OP_PROMOTE  = 3'd3;
    localparam logic [2:0] OP_CHECK    = 3'd4;

    localparam logic CFG_AGING_LIMIT = 1'b0;
    localparam logic CFG_BASE_SLICE  = 1'b1;

    localparam logic [15:0] AGING_LIMIT_RESET = 16'd150;
    localparam logic [7:0]  BASE_SLICE_RESET  = 8'd2;
    localparam logic [10:0] SLICE_MAX         = 11'd2047;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] job_id;
        logic [2:0]  level;
        logic [31:0] ready_stamp;
        logic [31:0] arrival_stamp;
        logic [31:0] now;
    } cmd_t;

    // result transaction, job_valid in bit 0
    typedef struct packed {
        logic        status;
        logic [6:0]  total_jobs;
        logic        stale_found;
        logic [10:0] time_slice;
        logic [1:0]  out_level;
        logic [15:0] out_job_id;
        logic        job_valid;
    } result_t;

endpackage

>>> rtl/multilevel_feedback_ready_queue.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_ready_queue
// Multi-level ready list with aging: a command front end feeding an engine.
// ----------------------------------------------------------------------------
// Add and insert append one entry to their level; dispatch reads the head of the
// first non-empty level and closes up the gap behind it. Promote and check scan
// levels 1 and up entry by entry; a promote that moves a job closes up the gap
// behind it and appends the job to the level one number lower (close-up and move).
// One command runs at a time; a two-entry command queue accepts ahead.
// Reset clears level counts, job total, state and config registers; entry RAM content is not cleared.
module multilevel_feedback_ready_queue #(
    parameter int NUM_LEVELS  = 4,
    parameter int LEVEL_DEPTH = 16,
    parameter int JOB_ID_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // job_id[15:0], target_level[18:16], ready_stamp[50:19],
    // arrival_stamp[82:51], now[114:83], zero pad
    input  logic [119:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // job_valid[0], out_job_id[16:1], out_level[18:17], time_slice[29:19],
    // stale_found[30], total_jobs[37:31], status[38], zero pad
    output logic [39:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);
    import mfrq_pkg::*;

    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;
    result_t     res;
    logic [15:0] aging_limit_reg;
    logic [7:0]  base_slice_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_limit_reg <= AGING_LIMIT_RESET;
            base_slice_reg  <= BASE_SLICE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AGING_LIMIT: aging_limit_reg <= cfg_data;
                CFG_BASE_SLICE:  base_slice_reg  <= cfg_data[7:0];
                default:         aging_limit_reg <= aging_limit_reg;
            endcase
        end
    end

    mfrq_front #(
        .NUM_LEVELS  (NUM_LEVELS),
        .JOB_ID_BITS (JOB_ID_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mfrq_back #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .JOB_ID_BITS (JOB_ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .aging_limit (aging_limit_reg),
        .base_slice  (base_slice_reg),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {1'b0, res};

    // a result without a job carries no id, level or slice
    a_no_job_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.job_valid |->
            res.out_job_id == '0 && res.time_slice == '0 && res.out_level == '0)
        else $error("job fields set without job_valid");

    a_valid_xor_refused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res.job_valid && res.status))
        else $error("job moved and refused in one result");

    a_stale_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.stale_found |-> !res.job_valid && !res.status)
        else $error("stale check result mixed with other outcome");

    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("queued command lost while engine busy");

endmodule

>>> rtl/mfrq_ram.sv
// ----------------------------------------------------------------------------
// mfrq_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mfrq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/mfrq_front.sv
// ----------------------------------------------------------------------------
// mfrq_front
// Accept input transactions, resolve the push level and queue up to two commands.
// ----------------------------------------------------------------------------
module mfrq_front #(
    parameter int NUM_LEVELS  = 4,
    parameter int JOB_ID_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [119:0]    s_tdata,
    input  logic [2:0]      s_tuser,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output mfrq_pkg::cmd_t  cmd
);
    import mfrq_pkg::*;

    localparam int QD = 2;
    localparam int QW = $clog2(QD);
    localparam logic [15:0] ID_MASK = (JOB_ID_BITS >= 16) ? 16'hFFFF
                                    : 16'((32'd1 << JOB_ID_BITS) - 32'd1);

    cmd_t            q_mem [QD];
    logic [QW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QW:0]     cnt_reg, cnt_next;
    cmd_t            in_cmd;
    logic            push, pop;

    always_comb
    begin
        in_cmd.op            = s_tuser;
        in_cmd.job_id        = s_tdata[15:0] & ID_MASK;
        in_cmd.ready_stamp   = s_tdata[50:19];
        in_cmd.arrival_stamp = s_tdata[82:51];
        in_cmd.now           = s_tdata[114:83];
        if (s_tuser == OP_ADD)
        begin
            in_cmd.level = 3'd1;
        end
        else if (32'(s_tdata[18:16]) < NUM_LEVELS)
        begin
            in_cmd.level = s_tdata[18:16];
        end
        else
        begin
            in_cmd.level = 3'd0;
        end
    end

    assign s_tready  = (cnt_reg < (QW+1)'(QD));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QD-1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QD-1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/mfrq_back.sv
// ----------------------------------------------------------------------------
// mfrq_back
// Sequencer over the entry RAM: push, pop, aging scan and close-up shift.
// ----------------------------------------------------------------------------
module mfrq_back #(
    parameter int NUM_LEVELS  = 4,
    parameter int LEVEL_DEPTH = 16,
    parameter int JOB_ID_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mfrq_pkg::cmd_t     cmd,
    input  logic [15:0]        aging_limit,
    input  logic [7:0]         base_slice,
    output logic               res_valid,
    input  logic               res_ready,
    output mfrq_pkg::result_t  res
);
    import mfrq_pkg::*;

    localparam int ID_W   = (JOB_ID_BITS < 16) ? JOB_ID_BITS : 16;
    localparam int EW     = ID_W + 64;
    localparam int DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int LV_W   = $clog2(NUM_LEVELS);
    localparam int POS_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int TOT_W  = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_TAKE     = 4'd4;
    localparam logic [3:0] S_SH_RD    = 4'd5;
    localparam logic [3:0] S_SH_WR    = 4'd6;
    localparam logic [3:0] S_MOVE     = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [LV_W-1:0]   lv_reg, lv_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [EW-1:0]     ent_reg, ent_next;
    logic [CNT_W-1:0]  counts_reg [NUM_LEVELS];
    logic [CNT_W-1:0]  counts_next [NUM_LEVELS];
    logic [TOT_W-1:0]  total_reg, total_next;
    result_t           acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_wdata, ram_rdata;

    logic [LV_W-1:0]   cidx;
    logic [CNT_W-1:0]  cnt_sel;
    logic              any_job;
    logic [LV_W-1:0]   first_lv;
    logic [LV_W-1:0]   push_lv;
    logic [31:0]       stamp;
    logic              old_hit;
    logic [14:0]       slice_wide;

    function automatic logic [AW-1:0] slot_addr(input logic [LV_W-1:0] lv,
                                               input logic [CNT_W-1:0] p);
        return AW'(lv) * AW'(LEVEL_DEPTH) + AW'(p[POS_W-1:0]);
    endfunction

    mfrq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign push_lv   = cmd_reg.level[LV_W-1:0];
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // one count read port, address picked by state
    always_comb
    begin
        case (state_reg)
            S_START:                 cidx = push_lv;
            S_SCAN_CHK, S_MOVE:      cidx = lv_reg - 1'b1;
            default:                 cidx = lv_reg;
        endcase
    end
    assign cnt_sel = counts_reg[cidx];

    always_comb
    begin
        any_job  = 1'b0;
        first_lv = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (counts_reg[i] != '0)
            begin
                any_job  = 1'b1;
                first_lv = LV_W'(i);
            end
        end
    end

    assign stamp   = (cmd_reg.op == OP_PROMOTE) ? ram_rdata[63:32] : ram_rdata[31:0];
    assign old_hit = (cmd_reg.now >= stamp) && ((cmd_reg.now - stamp) >= 32'(aging_limit));
    assign slice_wide = 15'(base_slice) << lv_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lv_next        = lv_reg;
        pos_next       = pos_reg;
        ent_next       = ent_reg;
        counts_next    = counts_reg;
        total_next     = total_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    acc_next   = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (cmd_reg.op)
                    OP_ADD, OP_INSERT:
                    begin
                        if (cnt_sel >= CNT_W'(LEVEL_DEPTH))
                        begin
                            acc_next.status = 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_addr(push_lv, cnt_sel);
                            ram_wdata = {cmd_reg.job_id[ID_W-1:0], cmd_reg.ready_stamp,
                                         cmd_reg.arrival_stamp};
                            counts_next[push_lv] = cnt_sel + 1'b1;
                            total_next = total_reg + 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    OP_DISPATCH:
                    begin
                        if (any_job)
                        begin
                            lv_next    = first_lv;
                            pos_next   = '0;
                            ram_re     = 1'b1;
                            ram_raddr  = slot_addr(first_lv, '0);
                            state_next = S_TAKE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    OP_PROMOTE, OP_CHECK:
                    begin
                        lv_next    = LV_W'(1);
                        pos_next   = '0;
                        state_next = S_SCAN_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (pos_reg >= cnt_sel)
                begin
                    if (lv_reg == LV_W'(NUM_LEVELS - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lv_next  = lv_reg + 1'b1;
                        pos_next = '0;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_addr(lv_reg, pos_reg);
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (!old_hit)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else if (cmd_reg.op == OP_CHECK)
                begin
                    acc_next.stale_found = 1'b1;
                    state_next = S_DONE;
                end
                else if (cnt_sel >= CNT_W'(LEVEL_DEPTH))
                begin
                    acc_next.status = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ent_next            = ram_rdata;
                    acc_next.job_valid  = 1'b1;
                    acc_next.out_job_id = 16'(ram_rdata[EW-1:64]);
                    acc_next.out_level  = 2'(lv_reg - 1'b1);
                    state_next          = S_SH_RD;
                end
            end
            S_TAKE:
            begin
                ent_next            = ram_rdata;
                acc_next.job_valid  = 1'b1;
                acc_next.out_job_id = 16'(ram_rdata[EW-1:64]);
                acc_next.out_level  = 2'(lv_reg);
                acc_next.time_slice = (slice_wide > 15'(SLICE_MAX)) ? SLICE_MAX
                                                                    : slice_wide[10:0];
                state_next          = S_SH_RD;
            end
            S_SH_RD:
            begin
                // close up the gap one entry at a time
                if ((CNT_W+1)'(pos_reg) + 1'b1 < (CNT_W+1)'(cnt_sel))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_addr(lv_reg, pos_reg + 1'b1);
                    state_next = S_SH_WR;
                end
                else
                begin
                    counts_next[lv_reg] = cnt_sel - 1'b1;
                    if (cmd_reg.op == OP_PROMOTE)
                    begin
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        total_next = total_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_addr(lv_reg, pos_reg);
                ram_wdata  = ram_rdata;
                pos_next   = pos_reg + 1'b1;
                state_next = S_SH_RD;
            end
            S_MOVE:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_addr(lv_reg - 1'b1, cnt_sel);
                ram_wdata = {ent_reg[EW-1:64], cmd_reg.now, ent_reg[31:0]};
                counts_next[lv_reg - 1'b1] = cnt_sel + 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_next            = acc_reg;
                    out_next.total_jobs = 7'(total_reg);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        lv_reg  <= lv_next;
        pos_reg <= pos_next;
        ent_reg <= ent_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            counts_reg    <= counts_next;
        end
    end

endmodule

>>> tb/sv/tb_multilevel_feedback_ready_queue.sv
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_ready_queue
// Drives command transactions into the ready queue and checks every result
// against a software copy of the four levels, with aging and slice rules.
// ----------------------------------------------------------------------------
module tb_multilevel_feedback_ready_queue;

    import mfrq_pkg::*;

    localparam int LEVELS = 4;
    localparam int DEPTH  = 16;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] job_id;
        logic [2:0]  level;
        logic [31:0] ready_stamp;
        logic [31:0] arrival_stamp;
        logic [31:0] now;
    } job_cmd_t;

    typedef struct {
        logic [15:0] id;
        logic [31:0] rdy;
        logic [31:0] arr;
    } job_entry_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         cfg_we;
    logic         cfg_index;
    logic [15:0]  cfg_data;

    job_entry_t  levels_q[LEVELS][$];
    logic [15:0] aging;
    logic [7:0]  slice_base;

    job_cmd_t pending_cmds[$];
    result_t  expected_results[$];

    int  errors;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  recv_hold_cycles;
    int  results_seen;
    int  dispatch_hits;
    int  promote_hits;
    int  stale_hits;
    int  refusals;

    multilevel_feedback_ready_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic bit aged(logic [31:0] now, logic [31:0] stamp);
        return (now >= stamp) && ((now - stamp) >= {16'd0, aging});
    endfunction

    function automatic int held_jobs();
        int s;
        s = 0;
        for (int lv = 0; lv < LEVELS; lv++)
            s += levels_q[lv].size();
        return s;
    endfunction

    function automatic void enqueue_cmd(job_cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Apply one command to the level copy and return the result it produces.
    function automatic result_t schedule_step(job_cmd_t c);
        result_t    r;
        job_entry_t e;
        int         lv;
        bit         done;
        logic [18:0] s;
        r = '0;
        e.id  = c.job_id;
        e.rdy = c.ready_stamp;
        e.arr = c.arrival_stamp;
        case (c.op)
            OP_ADD, OP_INSERT:
            begin
                lv = (c.op == OP_ADD) ? 1 : ((c.level < LEVELS) ? c.level : 0);
                if (levels_q[lv].size() >= DEPTH)
                    r.status = 1'b1;
                else
                    levels_q[lv].insert(levels_q[lv].size(), e);
            end
            OP_DISPATCH:
            begin
                for (lv = 0; lv < LEVELS; lv++)
                begin
                    if (levels_q[lv].size() > 0)
                    begin
                        e = levels_q[lv][0];
                        levels_q[lv].delete(0);
                        s = {11'd0, slice_base} << lv;
                        r.job_valid  = 1'b1;
                        r.out_job_id = e.id;
                        r.out_level  = lv[1:0];
                        r.time_slice = (s > SLICE_MAX) ? SLICE_MAX : s[10:0];
                        break;
                    end
                end
            end
            OP_PROMOTE:
            begin
                done = 0;
                for (lv = 1; lv < LEVELS && !done; lv++)
                begin
                    for (int p = 0; p < levels_q[lv].size(); p++)
                    begin
                        if (aged(c.now, levels_q[lv][p].rdy))
                        begin
                            done = 1;
                            if (levels_q[lv-1].size() >= DEPTH)
                                r.status = 1'b1;
                            else
                            begin
                                e = levels_q[lv][p];
                                levels_q[lv].delete(p);
                                e.rdy = c.now;
                                levels_q[lv-1].insert(levels_q[lv-1].size(), e);
                                r.job_valid  = 1'b1;
                                r.out_job_id = e.id;
                                r.out_level  = 2'(lv - 1);
                            end
                            break;
                        end
                    end
                end
            end
            OP_CHECK:
            begin
                for (lv = 1; lv < LEVELS; lv++)
                    for (int p = 0; p < levels_q[lv].size(); p++)
                        if (aged(c.now, levels_q[lv][p].arr))
                            r.stale_found = 1'b1;
            end
            default: ;
        endcase
        r.total_jobs = 7'(held_jobs());
        return r;
    endfunction

    // Driver: present the next pending command, advance on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                job_cmd_t c;
                c = pending_cmds[0];
                pending_cmds.delete(0);
                expected_results.insert(expected_results.size(), schedule_step(c));
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_cmds[0].op;
                    s_tdata  <= {5'd0, pending_cmds[0].now,
                                 pending_cmds[0].arrival_stamp,
                                 pending_cmds[0].ready_stamp,
                                 pending_cmds[0].level, pending_cmds[0].job_id};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_t got, exp_r;
                got = m_tdata[38:0];
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation: %h", got);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (got.job_valid !== exp_r.job_valid)
                    begin
                        $error("job_valid exp %0d got %0d", exp_r.job_valid, got.job_valid);
                        errors++;
                    end
                    if (got.out_job_id !== exp_r.out_job_id)
                    begin
                        $error("out_job_id exp %0d got %0d", exp_r.out_job_id,
                               got.out_job_id);
                        errors++;
                    end
                    if (got.out_level !== exp_r.out_level)
                    begin
                        $error("out_level exp %0d got %0d", exp_r.out_level, got.out_level);
                        errors++;
                    end
                    if (got.time_slice !== exp_r.time_slice)
                    begin
                        $error("time_slice exp %0d got %0d", exp_r.time_slice,
                               got.time_slice);
                        errors++;
                    end
                    if (got.stale_found !== exp_r.stale_found)
                    begin
                        $error("stale_found exp %0d got %0d", exp_r.stale_found,
                               got.stale_found);
                        errors++;
                    end
                    if (got.total_jobs !== exp_r.total_jobs)
                    begin
                        $error("total_jobs exp %0d got %0d", exp_r.total_jobs,
                               got.total_jobs);
                        errors++;
                    end
                    if (got.status !== exp_r.status)
                    begin
                        $error("status exp %0d got %0d", exp_r.status, got.status);
                        errors++;
                    end
                    dispatch_hits += (exp_r.job_valid && exp_r.time_slice != 0) ? 1 : 0;
                    promote_hits  += (exp_r.job_valid && exp_r.time_slice == 0) ? 1 : 0;
                    stale_hits    += exp_r.stale_found;
                    refusals      += exp_r.status;
                end
            end
            if (recv_hold_cycles > 0)
            begin
                recv_hold_cycles <= recv_hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic job_cmd_t make_cmd(logic [2:0] op, logic [15:0] id, logic [2:0] lv,
                                          logic [31:0] rdy, logic [31:0] arr,
                                          logic [31:0] now);
        job_cmd_t c;
        c.op = op;
        c.job_id = id;
        c.level = lv;
        c.ready_stamp = rdy;
        c.arrival_stamp = arr;
        c.now = now;
        return c;
    endfunction

    function automatic job_cmd_t random_cmd(logic [31:0] clock_now);
        job_cmd_t c;
        int       pick;
        c.job_id = 16'($urandom);
        c.level = 3'($urandom_range(7));
        c.now = clock_now + $urandom_range(400);
        c.ready_stamp = clock_now - $urandom_range(300) + $urandom_range(100);
        c.arrival_stamp = clock_now - $urandom_range(300) + $urandom_range(100);
        if ($urandom_range(19) == 0)
        begin
            c.ready_stamp = $urandom;
            c.arrival_stamp = $urandom;
            c.now = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 25)      c.op = OP_ADD;
        else if (pick < 45) c.op = OP_INSERT;
        else if (pick < 70) c.op = OP_DISPATCH;
        else if (pick < 85) c.op = OP_PROMOTE;
        else if (pick < 97) c.op = OP_CHECK;
        else                c.op = 3'(5 + $urandom_range(2));
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_AGING_LIMIT)
            aging = value;
        else
            slice_base = value[7:0];
    endtask

    task automatic random_phase(int count, int s_idle, int r_idle);
        logic [31:0] t;
        t = $urandom;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < count; i++)
        begin
            t += $urandom_range(60);
            enqueue_cmd(random_cmd(t));
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        recv_hold_cycles = 0;
        results_seen = 0;
        dispatch_hits = 0;
        promote_hits = 0;
        stale_hits = 0;
        refusals = 0;
        aging = AGING_LIMIT_RESET;
        slice_base = BASE_SLICE_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // Directed: empty dispatch, extremes, out-of-range level, aging edges.
        enqueue_cmd(make_cmd(OP_DISPATCH, 0, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(OP_ADD, 16'hFFFF, 7, 32'hFFFF_FFFF, 0, 0));
        enqueue_cmd(make_cmd(OP_INSERT, 16'h0001, 3'd7, 0, 32'hFFFF_FFFF, 0));
        enqueue_cmd(make_cmd(OP_INSERT, 16'h00A5, 3'd3, 100, 100, 0));
        enqueue_cmd(make_cmd(OP_INSERT, 16'h5A00, 3'd2, 500, 10, 0));
        enqueue_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 249));
        enqueue_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 250));
        enqueue_cmd(make_cmd(OP_PROMOTE, 0, 0, 0, 0, 249));
        enqueue_cmd(make_cmd(OP_PROMOTE, 0, 0, 0, 0, 32'hFFFF_FFFF));
        enqueue_cmd(make_cmd(3'd7, 0, 0, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            enqueue_cmd(make_cmd(OP_DISPATCH, 0, 0, 0, 0, 0));
        wait_drained();

        // Fill level 1 past its depth while the receiver holds off.
        recv_hold_cycles = 400;
        for (int i = 0; i < 18; i++)
            enqueue_cmd(make_cmd(OP_ADD, 16'(i), 0, 32'(i), 32'(i), 0));
        enqueue_cmd(make_cmd(OP_PROMOTE, 0, 0, 0, 0, 1000));
        wait_drained();

        write_reg(CFG_BASE_SLICE, 16'd255);
        write_reg(CFG_AGING_LIMIT, 16'd0);
        for (int i = 0; i < 16; i++)
            enqueue_cmd(make_cmd(OP_INSERT, 16'(16'h100 + i), 0, 0, 0, 0));
        enqueue_cmd(make_cmd(OP_PROMOTE, 0, 0, 0, 0, 5));
        enqueue_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 0));
        for (int i = 0; i < 40; i++)
            enqueue_cmd(make_cmd(OP_DISPATCH, 0, 0, 0, 0, 0));
        wait_drained();

        random_phase(100, 32, 87);
        write_reg(CFG_AGING_LIMIT, 16'hFFFF);
        write_reg(CFG_BASE_SLICE, 16'd1);
        random_phase(100, 87, 32);
        write_reg(CFG_AGING_LIMIT, 16'd40);
        write_reg(CFG_BASE_SLICE, 16'd0);
        random_phase(55, 0, 0);
        write_reg(CFG_BASE_SLICE, 16'd200);
        random_phase(55, 0, 0);

        $display("Covered %0d results: %0d dispatch/promote hits, %0d stale, %0d refused",
                 results_seen, dispatch_hits + promote_hits, stale_hits, refusals);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
